FILE: rtl/core/dense_plu_solver_defines.svh
// assertion macros for the dense lu solver
`ifndef DENSE_PLU_SOLVER_DEFINES_SVH
`define DENSE_PLU_SOLVER_DEFINES_SVH

// same-cycle implication
`define DPS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("dps assertion failed");

// next-cycle implication
`define DPS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("dps assertion failed");

`endif

FILE: rtl/core/dps_pkg.sv
// types, constants and codes shared by the dense lu solver
`timescale 1ns / 1ps
`default_nettype none
package dps_pkg;

  localparam int unsigned MaxOrder = 16;
  localparam int unsigned DataW    = 32;
  localparam int unsigned FracW    = 16;
  localparam int unsigned IdxW     = $clog2(MaxOrder);
  localparam int unsigned AddrW    = 2 * IdxW;
  localparam int unsigned OrderW   = 5;
  localparam int unsigned QuotW    = DataW + FracW;
  localparam int unsigned PaddrW   = 3;

  localparam logic [DataW-1:0] SatMax = {1'b0, {(DataW-1){1'b1}}};
  localparam logic [DataW-1:0] SatMin = {1'b1, {(DataW-1){1'b0}}};

  localparam logic [1:0] FUNC_LOAD_MAT = 2'd0;
  localparam logic [1:0] FUNC_LOAD_RHS = 2'd1;
  localparam logic [1:0] FUNC_FACTOR   = 2'd2;
  localparam logic [1:0] FUNC_SOLVE    = 2'd3;

  localparam logic [1:0] STATUS_OK           = 2'd0;
  localparam logic [1:0] STATUS_SINGULAR     = 2'd1;
  localparam logic [1:0] STATUS_NOT_FACTORED = 2'd2;

  localparam logic KIND_STATUS   = 1'b0;
  localparam logic KIND_SOLUTION = 1'b1;

  localparam logic REG_SIZE = 1'b0;

  typedef struct packed {
    logic [1:0]              func;
    logic [3:0]              row;
    logic [3:0]              col;
    logic signed [DataW-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic                    result_kind;
    logic [3:0]              index;
    logic signed [DataW-1:0] solution;
    logic [1:0]              status;
    logic                    last;
  } res_item_t;

  typedef enum logic [2:0] {
    MW_LOAD,
    MW_SWAP,
    MW_READ,
    MW_QUOT,
    MW_DIFF
  } mat_wsel_e;

  typedef enum logic [1:0] {
    X_HOLD,
    X_RHS,
    X_WV,
    X_SUB
  } x_op_e;

  typedef enum logic [5:0] {
    ST_IDLE,
    ST_PS_INIT, ST_PS_RD, ST_PS_CMP,
    ST_SW_RD1, ST_SW_RD2, ST_SW_WR1, ST_SW_WR2,
    ST_PM_RD1, ST_PM_RD2, ST_PM_WR1, ST_PM_WR2,
    ST_PV_RD, ST_PV_LD,
    ST_EL_RD, ST_EL_DIV, ST_EL_WAIT,
    ST_ER_RDP, ST_ER_RDI, ST_ER_WR,
    ST_FIN_RD, ST_FIN_CHK,
    ST_FW_PERM, ST_FW_RHS, ST_FW_X, ST_FW_RD, ST_FW_MUL, ST_FW_ACC, ST_FW_WR,
    ST_BK_RD0, ST_BK_X, ST_BK_RD, ST_BK_MUL, ST_BK_ACC,
    ST_BK_DRD, ST_BK_DIV, ST_BK_WAIT,
    ST_OUT_RD, ST_OUT_EM
  } state_e;

  typedef struct packed {
    logic [AddrW-1:0] mat_raddr;
    logic             mat_we;
    logic [AddrW-1:0] mat_waddr;
    mat_wsel_e        mat_wsel;
    logic             rhs_we;
    logic [IdxW-1:0]  wv_raddr;
    logic             wv_we;
    logic [IdxW-1:0]  wv_waddr;
    logic             wv_wquot;
    logic [IdxW-1:0]  perm_raddr;
    logic             perm_we;
    logic [IdxW-1:0]  perm_waddr;
    logic             perm_wtmp;
    logic             perm_clr;
    logic             ra_ld;
    logic             tmp_ld;
    logic             piv_ld;
    logic             c_ld;
    logic             best_clr;
    logic             best_ld;
    logic             mul_go;
    logic             mul_sel;
    x_op_e            x_op;
    logic             div_go;
    logic             div_sel;
    logic             emit;
    logic             emit_kind;
    logic [1:0]       emit_status;
    logic             emit_last;
    logic [IdxW-1:0]  emit_index;
  } cmd_t;

  typedef struct packed {
    logic mag_ge;
    logic rd_zero;
    logic div_done;
  } stat_t;

endpackage
`default_nettype wire

FILE: rtl/core/dps_div.sv
// iterative signed q16.16 divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module dps_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic signed [dps_pkg::DataW-1:0] num_i,
  input  logic signed [dps_pkg::DataW-1:0] den_i,
  output logic                            done_o,
  output logic signed [dps_pkg::DataW-1:0] quot_o
);
  import dps_pkg::*;

  localparam int unsigned CntW = $clog2(QuotW);

  logic             busy_q, done_q;
  logic [CntW-1:0]  cnt_q;
  logic             neg_q, zero_q;
  logic [QuotW-1:0] dvd_q;
  logic [DataW-1:0] dsr_q;
  logic [DataW-1:0] rem_q;

  logic [DataW-1:0] num_mag, den_mag;
  logic [DataW:0]   rem_sh, rem_sub;
  logic             bit_w;

  assign num_mag = num_i[DataW-1] ? (~num_i + 1'b1) : num_i;
  assign den_mag = den_i[DataW-1] ? (~den_i + 1'b1) : den_i;
  assign rem_sh  = {rem_q, dvd_q[QuotW-1]};
  assign rem_sub = rem_sh - {1'b0, dsr_q};
  assign bit_w   = (rem_sh >= {1'b0, dsr_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(QuotW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q  <= num_i[DataW-1] ^ den_i[DataW-1];
      zero_q <= (den_i == '0);
      dvd_q  <= {num_mag, {FracW{1'b0}}};
      dsr_q  <= den_mag;
      rem_q  <= '0;
    end else if (busy_q) begin
      rem_q <= bit_w ? rem_sub[DataW-1:0] : rem_sh[DataW-1:0];
      dvd_q <= {dvd_q[QuotW-2:0], bit_w};
    end
  end

  always_comb begin
    if (zero_q) begin
      quot_o = '0;
    end else if (!neg_q) begin
      quot_o = (dvd_q > QuotW'(SatMax)) ? SatMax : dvd_q[DataW-1:0];
    end else begin
      quot_o = (dvd_q > QuotW'(SatMin)) ? SatMin : (~dvd_q[DataW-1:0] + 1'b1);
    end
  end

  assign done_o = done_q;

endmodule
`default_nettype wire

FILE: rtl/core/dps_dp.sv
// datapath: matrix, vector and permutation stores, multiplier, divider, result register
`timescale 1ns / 1ps
`default_nettype none
module dps_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dps_pkg::in_item_t   item_i,
  input  dps_pkg::cmd_t       cmd_i,
  output dps_pkg::stat_t      stat_o,
  output logic                res_valid_o,
  output dps_pkg::res_item_t  res_o
);
  import dps_pkg::*;

  logic signed [DataW-1:0] mat_mem [MaxOrder*MaxOrder];
  logic signed [DataW-1:0] rhs_mem [MaxOrder];
  logic signed [DataW-1:0] wv_mem  [MaxOrder];
  logic [IdxW-1:0]         perm_mem [MaxOrder];
  logic [MaxOrder-1:0]     perm_vld_q;

  logic signed [DataW-1:0]   mat_rd_q, rhs_rd_q, wv_rd_q;
  logic [IdxW-1:0]           perm_rd_q, tmp_q;
  logic signed [DataW-1:0]   ra_q, piv_q, c_q, x_q;
  logic [DataW-1:0]          best_q;
  logic signed [2*DataW-1:0] prod_q;
  logic                      res_valid_q;
  res_item_t                 res_q;

  logic signed [DataW-1:0]   mat_wdata, mul_a, mul_b, mq, minu, diff, quot;
  logic signed [DataW-1:0]   div_num, div_den;
  logic signed [2*DataW-1:0] mq_full;
  logic signed [DataW:0]     diff_w;
  logic [DataW-1:0]          rd_mag;
  logic                      div_done;

  dps_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_go),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  assign div_num = cmd_i.div_sel ? x_q : mat_rd_q;
  assign div_den = cmd_i.div_sel ? mat_rd_q : piv_q;

  assign mul_a   = cmd_i.mul_sel ? mat_rd_q : c_q;
  assign mul_b   = cmd_i.mul_sel ? wv_rd_q : mat_rd_q;
  assign mq_full = prod_q >>> FracW;

  always_comb begin
    if (mq_full[2*DataW-1:DataW-1] == '0 || mq_full[2*DataW-1:DataW-1] == '1) begin
      mq = mq_full[DataW-1:0];
    end else begin
      mq = mq_full[2*DataW-1] ? SatMin : SatMax;
    end
  end

  assign minu   = (cmd_i.x_op == X_SUB) ? x_q : mat_rd_q;
  assign diff_w = {minu[DataW-1], minu} - {mq[DataW-1], mq};
  assign diff   = (diff_w[DataW] != diff_w[DataW-1]) ?
                  (diff_w[DataW] ? SatMin : SatMax) : diff_w[DataW-1:0];

  assign rd_mag = mat_rd_q[DataW-1] ? (~mat_rd_q + 1'b1) : mat_rd_q;

  always_comb begin
    case (cmd_i.mat_wsel)
      MW_LOAD: mat_wdata = item_i.value;
      MW_SWAP: mat_wdata = ra_q;
      MW_READ: mat_wdata = mat_rd_q;
      MW_QUOT: mat_wdata = quot;
      MW_DIFF: mat_wdata = diff;
      default: mat_wdata = mat_rd_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mat_we) begin
      mat_mem[cmd_i.mat_waddr] <= mat_wdata;
    end
    mat_rd_q <= mat_mem[cmd_i.mat_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rhs_we) begin
      rhs_mem[item_i.row] <= item_i.value;
    end
    rhs_rd_q <= rhs_mem[perm_rd_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wv_we) begin
      wv_mem[cmd_i.wv_waddr] <= cmd_i.wv_wquot ? quot : x_q;
    end
    wv_rd_q <= wv_mem[cmd_i.wv_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.perm_we) begin
      perm_mem[cmd_i.perm_waddr] <= cmd_i.perm_wtmp ? tmp_q : perm_rd_q;
    end
    perm_rd_q <= perm_vld_q[cmd_i.perm_raddr] ? perm_mem[cmd_i.perm_raddr]
                                              : cmd_i.perm_raddr;
  end

  // unwritten permutation entries read as identity
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      perm_vld_q <= '0;
    end else if (cmd_i.perm_clr) begin
      perm_vld_q <= '0;
    end else if (cmd_i.perm_we) begin
      perm_vld_q[cmd_i.perm_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ra_ld)  ra_q  <= mat_rd_q;
    if (cmd_i.tmp_ld) tmp_q <= perm_rd_q;
    if (cmd_i.piv_ld) piv_q <= mat_rd_q;
    if (cmd_i.c_ld)   c_q   <= quot;
    if (cmd_i.best_clr) begin
      best_q <= '0;
    end else if (cmd_i.best_ld) begin
      best_q <= rd_mag;
    end
    if (cmd_i.mul_go) prod_q <= mul_a * mul_b;
    case (cmd_i.x_op)
      X_RHS:   x_q <= rhs_rd_q;
      X_WV:    x_q <= wv_rd_q;
      X_SUB:   x_q <= diff;
      default: x_q <= x_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      res_q.result_kind <= cmd_i.emit_kind;
      res_q.index       <= cmd_i.emit_index;
      res_q.solution    <= (cmd_i.emit_kind == KIND_SOLUTION) ? wv_rd_q : '0;
      res_q.status      <= cmd_i.emit_status;
      res_q.last        <= cmd_i.emit_last;
    end
  end

  assign stat_o.mag_ge   = (rd_mag >= best_q);
  assign stat_o.rd_zero  = (mat_rd_q == '0);
  assign stat_o.div_done = div_done;
  assign res_valid_o     = res_valid_q;
  assign res_o           = res_q;

endmodule
`default_nettype wire

FILE: rtl/core/dps_ctrl.sv
// controller: command decode and the factor and solve sequencer
`timescale 1ns / 1ps
`default_nettype none
`include "dense_plu_solver_defines.svh"
module dps_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  dps_pkg::in_item_t        item_i,
  input  logic                     cfg_wr_i,
  input  logic [dps_pkg::IdxW-1:0] n_m1_i,
  input  dps_pkg::stat_t           stat_i,
  output dps_pkg::cmd_t            cmd_o,
  output logic                     busy_o
);
  import dps_pkg::*;

  state_e          state_q, state_d;
  logic [IdxW-1:0] p_q, p_d, i_q, i_d, j_q, j_d, pm_q, pm_d;
  logic            fact_q, fact_d, sing_q, sing_d, run_q, run_d;
  logic            sing_fin;

  assign sing_fin = run_q | stat_i.rd_zero;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      p_q     <= '0;
      i_q     <= '0;
      j_q     <= '0;
      pm_q    <= '0;
      fact_q  <= 1'b0;
      sing_q  <= 1'b0;
      run_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      p_q     <= p_d;
      i_q     <= i_d;
      j_q     <= j_d;
      pm_q    <= pm_d;
      fact_q  <= fact_d;
      sing_q  <= sing_d;
      run_q   <= run_d;
    end
  end

  always_comb begin
    state_d = state_q;
    p_d     = p_q;
    i_d     = i_q;
    j_d     = j_q;
    pm_d    = pm_q;
    fact_d  = fact_q;
    sing_d  = sing_q;
    run_d   = run_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          unique case (item_i.func)
            FUNC_LOAD_MAT: begin
              cmd_o.mat_we    = 1'b1;
              cmd_o.mat_waddr = {item_i.row, item_i.col};
              cmd_o.mat_wsel  = MW_LOAD;
              fact_d          = 1'b0;
            end
            FUNC_LOAD_RHS: begin
              cmd_o.rhs_we = 1'b1;
            end
            FUNC_FACTOR: begin
              cmd_o.perm_clr = 1'b1;
              p_d            = '0;
              run_d          = 1'b0;
              state_d        = (n_m1_i == '0) ? ST_FIN_RD : ST_PS_INIT;
            end
            FUNC_SOLVE: begin
              if (!fact_q || sing_q) begin
                cmd_o.emit        = 1'b1;
                cmd_o.emit_kind   = KIND_STATUS;
                cmd_o.emit_status = fact_q ? STATUS_SINGULAR : STATUS_NOT_FACTORED;
                cmd_o.emit_last   = 1'b1;
              end else begin
                i_d     = '0;
                state_d = ST_FW_PERM;
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_PS_INIT: begin
        cmd_o.best_clr = 1'b1;
        i_d            = p_q;
        pm_d           = p_q;
        state_d        = ST_PS_RD;
      end
      ST_PS_RD: begin
        cmd_o.mat_raddr = {i_q, p_q};
        state_d         = ST_PS_CMP;
      end
      ST_PS_CMP: begin
        // ties go to the later row
        if (stat_i.mag_ge) begin
          cmd_o.best_ld = 1'b1;
          pm_d          = i_q;
        end
        if (i_q == n_m1_i) begin
          j_d     = '0;
          state_d = ST_SW_RD1;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = ST_PS_RD;
        end
      end
      ST_SW_RD1: begin
        cmd_o.mat_raddr = {p_q, j_q};
        state_d         = ST_SW_RD2;
      end
      ST_SW_RD2: begin
        cmd_o.ra_ld     = 1'b1;
        cmd_o.mat_raddr = {pm_q, j_q};
        state_d         = ST_SW_WR1;
      end
      ST_SW_WR1: begin
        cmd_o.mat_we    = 1'b1;
        cmd_o.mat_waddr = {p_q, j_q};
        cmd_o.mat_wsel  = MW_READ;
        state_d         = ST_SW_WR2;
      end
      ST_SW_WR2: begin
        cmd_o.mat_we    = 1'b1;
        cmd_o.mat_waddr = {pm_q, j_q};
        cmd_o.mat_wsel  = MW_SWAP;
        if (j_q == n_m1_i) begin
          state_d = ST_PM_RD1;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = ST_SW_RD1;
        end
      end
      ST_PM_RD1: begin
        cmd_o.perm_raddr = p_q;
        state_d          = ST_PM_RD2;
      end
      ST_PM_RD2: begin
        cmd_o.tmp_ld     = 1'b1;
        cmd_o.perm_raddr = pm_q;
        state_d          = ST_PM_WR1;
      end
      ST_PM_WR1: begin
        cmd_o.perm_we    = 1'b1;
        cmd_o.perm_waddr = p_q;
        state_d          = ST_PM_WR2;
      end
      ST_PM_WR2: begin
        cmd_o.perm_we    = 1'b1;
        cmd_o.perm_waddr = pm_q;
        cmd_o.perm_wtmp  = 1'b1;
        state_d          = ST_PV_RD;
      end
      ST_PV_RD: begin
        cmd_o.mat_raddr = {p_q, p_q};
        state_d         = ST_PV_LD;
      end
      ST_PV_LD: begin
        cmd_o.piv_ld = 1'b1;
        if (stat_i.rd_zero) run_d = 1'b1;
        i_d     = p_q + 1'b1;
        state_d = ST_EL_RD;
      end
      ST_EL_RD: begin
        cmd_o.mat_raddr = {i_q, p_q};
        state_d         = ST_EL_DIV;
      end
      ST_EL_DIV: begin
        cmd_o.div_go  = 1'b1;
        cmd_o.div_sel = 1'b0;
        state_d       = ST_EL_WAIT;
      end
      ST_EL_WAIT: begin
        if (stat_i.div_done) begin
          cmd_o.c_ld      = 1'b1;
          cmd_o.mat_we    = 1'b1;
          cmd_o.mat_waddr = {i_q, p_q};
          cmd_o.mat_wsel  = MW_QUOT;
          j_d             = p_q + 1'b1;
          state_d         = ST_ER_RDP;
        end
      end
      ST_ER_RDP: begin
        cmd_o.mat_raddr = {p_q, j_q};
        state_d         = ST_ER_RDI;
      end
      ST_ER_RDI: begin
        cmd_o.mat_raddr = {i_q, j_q};
        cmd_o.mul_go    = 1'b1;
        cmd_o.mul_sel   = 1'b0;
        state_d         = ST_ER_WR;
      end
      ST_ER_WR: begin
        cmd_o.mat_we    = 1'b1;
        cmd_o.mat_waddr = {i_q, j_q};
        cmd_o.mat_wsel  = MW_DIFF;
        if (j_q != n_m1_i) begin
          j_d     = j_q + 1'b1;
          state_d = ST_ER_RDP;
        end else if (i_q != n_m1_i) begin
          i_d     = i_q + 1'b1;
          state_d = ST_EL_RD;
        end else begin
          p_d     = p_q + 1'b1;
          state_d = ((p_q + 1'b1) == n_m1_i) ? ST_FIN_RD : ST_PS_INIT;
        end
      end
      ST_FIN_RD: begin
        cmd_o.mat_raddr = {n_m1_i, n_m1_i};
        state_d         = ST_FIN_CHK;
      end
      ST_FIN_CHK: begin
        sing_d            = sing_fin;
        fact_d            = 1'b1;
        cmd_o.emit        = 1'b1;
        cmd_o.emit_kind   = KIND_STATUS;
        cmd_o.emit_status = sing_fin ? STATUS_SINGULAR : STATUS_OK;
        cmd_o.emit_last   = 1'b1;
        state_d           = ST_IDLE;
      end
      ST_FW_PERM: begin
        cmd_o.perm_raddr = i_q;
        state_d          = ST_FW_RHS;
      end
      ST_FW_RHS: begin
        state_d = ST_FW_X;
      end
      ST_FW_X: begin
        cmd_o.x_op = X_RHS;
        j_d        = '0;
        state_d    = (i_q == '0) ? ST_FW_WR : ST_FW_RD;
      end
      ST_FW_RD: begin
        cmd_o.mat_raddr = {i_q, j_q};
        cmd_o.wv_raddr  = j_q;
        state_d         = ST_FW_MUL;
      end
      ST_FW_MUL: begin
        cmd_o.mul_go  = 1'b1;
        cmd_o.mul_sel = 1'b1;
        state_d       = ST_FW_ACC;
      end
      ST_FW_ACC: begin
        cmd_o.x_op = X_SUB;
        if ((j_q + 1'b1) == i_q) begin
          state_d = ST_FW_WR;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = ST_FW_RD;
        end
      end
      ST_FW_WR: begin
        cmd_o.wv_we    = 1'b1;
        cmd_o.wv_waddr = i_q;
        if (i_q == n_m1_i) begin
          state_d = ST_BK_RD0;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = ST_FW_PERM;
        end
      end
      ST_BK_RD0: begin
        cmd_o.wv_raddr = i_q;
        state_d        = ST_BK_X;
      end
      ST_BK_X: begin
        cmd_o.x_op = X_WV;
        j_d        = i_q + 1'b1;
        state_d    = (i_q == n_m1_i) ? ST_BK_DRD : ST_BK_RD;
      end
      ST_BK_RD: begin
        cmd_o.mat_raddr = {i_q, j_q};
        cmd_o.wv_raddr  = j_q;
        state_d         = ST_BK_MUL;
      end
      ST_BK_MUL: begin
        cmd_o.mul_go  = 1'b1;
        cmd_o.mul_sel = 1'b1;
        state_d       = ST_BK_ACC;
      end
      ST_BK_ACC: begin
        cmd_o.x_op = X_SUB;
        if (j_q == n_m1_i) begin
          state_d = ST_BK_DRD;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = ST_BK_RD;
        end
      end
      ST_BK_DRD: begin
        cmd_o.mat_raddr = {i_q, i_q};
        state_d         = ST_BK_DIV;
      end
      ST_BK_DIV: begin
        cmd_o.div_go  = 1'b1;
        cmd_o.div_sel = 1'b1;
        state_d       = ST_BK_WAIT;
      end
      ST_BK_WAIT: begin
        if (stat_i.div_done) begin
          cmd_o.wv_we    = 1'b1;
          cmd_o.wv_waddr = i_q;
          cmd_o.wv_wquot = 1'b1;
          if (i_q == '0) begin
            state_d = ST_OUT_RD;
          end else begin
            i_d     = i_q - 1'b1;
            state_d = ST_BK_RD0;
          end
        end
      end
      ST_OUT_RD: begin
        cmd_o.wv_raddr = i_q;
        state_d        = ST_OUT_EM;
      end
      ST_OUT_EM: begin
        cmd_o.emit        = 1'b1;
        cmd_o.emit_kind   = KIND_SOLUTION;
        cmd_o.emit_status = STATUS_OK;
        cmd_o.emit_index  = i_q;
        cmd_o.emit_last   = (i_q == n_m1_i);
        if (i_q == n_m1_i) begin
          state_d = ST_IDLE;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = ST_OUT_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (cfg_wr_i) fact_d = 1'b0;
  end

  assign busy_o = (state_q != ST_IDLE);

  `DPS_ASSERT_IMP(a_sol_needs_clean_factor, clk_i, rst_ni,
    cmd_o.emit && cmd_o.emit_kind == KIND_SOLUTION, fact_q && !sing_q)
  `DPS_ASSERT_NXT(a_div_takes_cycles, clk_i, rst_ni, cmd_o.div_go, !stat_i.div_done)
  `DPS_ASSERT_NXT(a_last_ends_command, clk_i, rst_ni,
    cmd_o.emit && cmd_o.emit_last, state_q == ST_IDLE)

endmodule
`default_nettype wire

FILE: rtl/core/dense_plu_solver.sv
// top level of the dense lu solver with partial pivoting and its register port
`timescale 1ns / 1ps
`default_nettype none
// Load items (matrix or right-hand side element) are taken every cycle while
// idle, with no result. A factor item walks the stored matrix with one
// memory port: per column p a pivot search, the row swap, the permutation
// swap and pivot read, and per row below the pivot the quotient (read,
// start, 48 serial divide steps and the done cycle) and a multiply-subtract
// per element to its right, ending in one status item. A solve item does a
// multiply-subtract per substitution term and a serial divide per diagonal,
// then emits one solution item per index; results carry a one-cycle strobe
// and cannot be held off by the receiver.
module dense_plu_solver (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  dps_pkg::in_item_t            item_i,
  output logic                         res_valid_o,
  output dps_pkg::res_item_t           res_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dps_pkg::PaddrW-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import dps_pkg::*;

  logic [OrderW-1:0] size_q;
  logic              cfg_wr;
  logic [IdxW-1:0]   n_m1;
  cmd_t              cmd;
  stat_t             stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_SIZE);
  assign prdata = (paddr[2] == REG_SIZE) ? {{(32-OrderW){1'b0}}, size_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= OrderW'(MaxOrder);
    end else if (cfg_wr) begin
      size_q <= pwdata[OrderW-1:0];
    end
  end

  always_comb begin
    if (size_q == '0) begin
      n_m1 = '0;
    end else if (size_q > OrderW'(MaxOrder)) begin
      n_m1 = IdxW'(MaxOrder - 1);
    end else begin
      n_m1 = IdxW'(size_q - 1'b1);
    end
  end

  dps_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .item_i   (item_i),
    .cfg_wr_i (cfg_wr),
    .n_m1_i   (n_m1),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  dps_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule
`default_nettype wire

FILE: tb/tb_dense_plu_solver.sv
// self-checking testbench for the dense lu solver with partial pivoting
`timescale 1ns / 1ps
module tb_dense_plu_solver;
  import dps_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start;
  logic busy;
  in_item_t item_i;
  logic res_valid_o;
  res_item_t res_o;
  logic psel, penable, pwrite;
  logic [PaddrW-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  dense_plu_solver uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .item_i(item_i),
    .res_valid_o(res_valid_o), .res_o(res_o), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk_i = ~clk_i;

  // shadow of the solver state
  longint mat [MaxOrder*MaxOrder];
  longint rhs [MaxOrder];
  longint wv [MaxOrder];
  int perm [MaxOrder];
  bit factored, singular;
  int unsigned order_reg;

  bit mat_seen [MaxOrder*MaxOrder];
  bit rhs_seen [MaxOrder];
  in_item_t pending [$];
  res_item_t awaited [$];
  int errors = 0;
  int n_items = 0;
  int gap = 0;
  logic nxt;
  bit quiet = 0;

  function automatic longint sat(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return sat((a * b) >>> FracW);
  endfunction

  function automatic longint qdiv(longint a, longint b);
    if (b == 0) return 0;
    return sat((a * 65536) / b);
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic int active_order();
    if (order_reg == 0) return 1;
    if (order_reg > MaxOrder) return MaxOrder;
    return order_reg;
  endfunction

  task automatic push_status(logic [1:0] st);
    res_item_t r;
    r = '0;
    r.result_kind = KIND_STATUS;
    r.status = st;
    r.last = 1'b1;
    awaited.push_back(r);
  endtask

  task automatic run_factor();
    int n, pm, tp;
    longint best, m, t, piv, c;
    bit sg;
    n = active_order();
    sg = 0;
    for (int i = 0; i < MaxOrder; i++) perm[i] = i;
    for (int p = 0; p + 1 < n; p++) begin
      best = 0;
      pm = p;
      for (int i = p; i < n; i++) begin
        m = mag(mat[i*MaxOrder+p]);
        if (best <= m) begin
          best = m;
          pm = i;
        end
      end
      for (int j = 0; j < n; j++) begin
        t = mat[p*MaxOrder+j];
        mat[p*MaxOrder+j] = mat[pm*MaxOrder+j];
        mat[pm*MaxOrder+j] = t;
      end
      tp = perm[p];
      perm[p] = perm[pm];
      perm[pm] = tp;
      piv = mat[p*MaxOrder+p];
      if (piv == 0) sg = 1;
      for (int i = p + 1; i < n; i++) begin
        c = qdiv(mat[i*MaxOrder+p], piv);
        for (int j = p + 1; j < n; j++)
          mat[i*MaxOrder+j] = sat(mat[i*MaxOrder+j] - qmul(c, mat[p*MaxOrder+j]));
        mat[i*MaxOrder+p] = c;
      end
    end
    if (mat[(n-1)*MaxOrder+n-1] == 0) sg = 1;
    singular = sg;
    factored = 1;
    push_status(sg ? STATUS_SINGULAR : STATUS_OK);
  endtask

  task automatic run_solve();
    int n;
    longint x;
    res_item_t r;
    n = active_order();
    if (!factored) begin
      push_status(STATUS_NOT_FACTORED);
    end else if (singular) begin
      push_status(STATUS_SINGULAR);
    end else begin
      for (int i = 0; i < n; i++) begin
        x = rhs[perm[i]];
        for (int j = 0; j < i; j++) x = sat(x - qmul(mat[i*MaxOrder+j], wv[j]));
        wv[i] = x;
      end
      for (int i = n - 1; i >= 0; i--) begin
        x = wv[i];
        for (int j = i + 1; j < n; j++) x = sat(x - qmul(mat[i*MaxOrder+j], wv[j]));
        wv[i] = qdiv(x, mat[i*MaxOrder+i]);
      end
      for (int i = 0; i < n; i++) begin
        r = '0;
        r.result_kind = KIND_SOLUTION;
        r.index = i[3:0];
        r.solution = wv[i][31:0];
        r.status = STATUS_OK;
        r.last = (i == n - 1);
        awaited.push_back(r);
      end
    end
  endtask

  task automatic predict(in_item_t it);
    case (it.func)
      FUNC_LOAD_MAT: begin
        mat[it.row*MaxOrder+it.col] = longint'(it.value);
        factored = 0;
      end
      FUNC_LOAD_RHS: rhs[it.row] = longint'(it.value);
      FUNC_FACTOR:   run_factor();
      default:       run_solve();
    endcase
  endtask

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      item_i <= '0;
      gap = 0;
    end else begin
      nxt = start;
      if (start && !busy) begin
        predict(item_i);
        nxt = 1'b0;
        gap = pick_gap();
      end
      if (!nxt) begin
        if (gap > 0) begin
          gap--;
        end else if (pending.size() > 0) begin
          item_i <= pending.pop_front();
          nxt = 1'b1;
        end
      end
      start <= nxt;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t unexpected item: actual %p", $time, res_o);
      end else begin
        res_item_t e;
        e = awaited.pop_front();
        if (res_o.result_kind !== e.result_kind || res_o.index !== e.index ||
            res_o.solution !== e.solution || res_o.status !== e.status ||
            res_o.last !== e.last) begin
          errors++;
          $display("%0t mismatch: expected %p actual %p", $time, e, res_o);
        end
      end
    end
  end

  task automatic send(logic [1:0] f, int r, int c, logic signed [31:0] v);
    in_item_t it;
    it.func = f;
    it.row = r[3:0];
    it.col = c[3:0];
    it.value = v;
    if (f == FUNC_LOAD_MAT) mat_seen[it.row*MaxOrder+it.col] = 1;
    if (f == FUNC_LOAD_RHS) rhs_seen[it.row] = 1;
    pending.push_back(it);
    n_items++;
  endtask

  task automatic drain();
    while (!(pending.size() == 0 && !start && !busy && awaited.size() == 0))
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_order(logic [31:0] v);
    drain();
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= REG_SIZE * 4;
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    order_reg = v & 31;
    factored = 0;
  endtask

  function automatic logic signed [31:0] pick_val(int kind, bit diag);
    case (kind)
      1: return $urandom;
      2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return diag ? (($urandom_range(0, 1) ? 1 : -1) * $urandom_range(400000, 2000000))
                           : $urandom_range(0, 262144) - 131072;
    endcase
  endfunction

  // kind: 0 well conditioned, 1 full range, 2 extremes, 3 singular column, 4 tied pivots
  task automatic load_system(int n, int kind);
    int zc;
    logic signed [31:0] v;
    zc = $urandom_range(0, n - 1);
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        if (kind == 3 && j == zc) v = 0;
        else if (kind == 4 && j == 0) v = ((i % 2) ? 1 : -1) * 32'sd196608;
        else v = pick_val(kind > 2 ? 0 : kind, i == j);
        send(FUNC_LOAD_MAT, i, j, v);
      end
      send(FUNC_LOAD_RHS, i, 0, pick_val(kind == 1 ? 1 : 0, 0));
    end
  endtask

  task automatic fill_gaps(int n);
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++)
        if (!mat_seen[i*MaxOrder+j]) send(FUNC_LOAD_MAT, i, j, pick_val(0, i == j));
      if (!rhs_seen[i]) send(FUNC_LOAD_RHS, i, 0, pick_val(0, 0));
    end
  endtask

  task automatic run_phase(int n, int rounds);
    int k;
    for (int r = 0; r < rounds; r++) begin
      k = $urandom_range(0, 9);
      if (k < 5) load_system(n, 0);
      else if (k < 7) load_system(n, $urandom_range(1, 2));
      else load_system(n, $urandom_range(3, 4));
      for (int q = $urandom_range(0, 3); q > 0; q--)
        send($urandom_range(0, 1), $urandom_range(0, 15), $urandom_range(0, 15), $urandom);
      fill_gaps(n);
      if ($urandom_range(0, 5) == 0) send(FUNC_SOLVE, 0, 0, 0);
      send(FUNC_FACTOR, $urandom, $urandom, $urandom);
      send(FUNC_SOLVE, $urandom, $urandom, $urandom);
      if ($urandom_range(0, 2) == 0) begin
        send(FUNC_LOAD_RHS, $urandom_range(0, n - 1), 0, pick_val(0, 0));
        send(FUNC_SOLVE, 0, 0, 0);
      end
      if ($urandom_range(0, 4) == 0) drain();
    end
  endtask

  initial begin
    int sizes [4] = '{2, 0, 3, 5};
    rst_ni = 1'b0;
    start = 1'b0;
    item_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    for (int i = 0; i < MaxOrder; i++) perm[i] = i;
    factored = 0;
    singular = 0;
    order_reg = 16;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: solve unfactored, 2x2 extremes, matrix load drops factored state
    send(FUNC_SOLVE, 0, 0, 0);
    write_order(2);
    quiet = 1;
    send(FUNC_LOAD_MAT, 0, 0, 32'sh7fffffff);
    send(FUNC_LOAD_MAT, 0, 1, 32'sh80000000);
    send(FUNC_LOAD_MAT, 1, 0, 32'sh80000001);
    send(FUNC_LOAD_MAT, 1, 1, 32'sh00010000);
    send(FUNC_LOAD_RHS, 0, 15, 32'sh80000000);
    send(FUNC_LOAD_RHS, 1, 0, 32'sh7fffffff);
    send(FUNC_FACTOR, 0, 0, 0);
    send(FUNC_SOLVE, 15, 15, 32'shffffffff);
    send(FUNC_LOAD_RHS, 1, 0, 32'sh00020000);
    send(FUNC_SOLVE, 0, 0, 0);
    send(FUNC_LOAD_MAT, 15, 15, 32'sh0);
    send(FUNC_SOLVE, 0, 0, 0);
    send(FUNC_LOAD_MAT, 0, 0, 32'sh0);
    send(FUNC_LOAD_MAT, 1, 0, 32'sh0);
    send(FUNC_FACTOR, 0, 0, 0);
    send(FUNC_SOLVE, 0, 0, 0);
    drain();
    quiet = 0;

    foreach (sizes[s]) begin
      write_order(sizes[s] | ($urandom & 32'hffffffe0));
      quiet = (s % 3 == 1);
      run_phase(active_order(), 3);
    end
    quiet = 0;
    while (n_items < 240) begin
      write_order($urandom_range(1, 6));
      run_phase(active_order(), 1);
    end
    drain();
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #40ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
